>>> design/cle_pkg.sv
package cle_pkg;

  // payload field widths
  localparam int OP_W      = 3;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 9;
  localparam int ST_W      = 2;

  // request codes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_POS  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_WALK   = 6'b000100,
    S_RDATA  = 6'b001000,
    S_PUTV   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

endpackage

>>> design/cle_in_if.sv
interface cle_in_if;
  logic                               valid;
  logic                               ready;
  logic        [cle_pkg::OP_W-1:0]    operation;
  logic        [cle_pkg::POS_W-1:0]   position;
  logic signed [cle_pkg::VAL_W-1:0]   value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

>>> design/cle_out_if.sv
interface cle_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cle_pkg::VAL_W-1:0]     read_value;
  logic        [cle_pkg::POS_W-1:0]     found_position;
  logic                                 found;
  logic        [cle_pkg::CNT_OUT_W-1:0] count;
  logic        [cle_pkg::ST_W-1:0]      status;

  modport source (output valid, output read_value, output found_position,
                  output found, output count, output status, input ready);
  modport sink   (input valid, input read_value, input found_position,
                  input found, input count, input status, output ready);
endinterface

>>> design/contiguous_list_engine_top.sv
// Contiguous list engine: an ordered list of signed 32-bit words packed at
// the front of a DEPTH-entry store, plus an element count.
// in_ch carries one request word (operation, position, value); out_ch
// returns one result word per request (read value, found position, found
// flag, count after the request, status). Both use valid/ready.
// Requests are taken one at a time: in_ch.ready is high only while the
// sequencer is idle. A read goes from decode through a read-data state to
// the response; a write, a rejected request or an ignored code goes from
// decode straight to the response. Insert and remove move N elements, and
// search scans N elements, through the single read port of the store, one
// element per cycle; insert then writes the new value before the response.
// The next request is taken in the cycle after a result is handed over.
// The result sits in an output register; a new request is accepted while
// it waits, and that request's own result holds in the sequencer until the
// receiver takes the previous word.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. Store contents are not cleared; only entries below the count are
// ever read, and each of them was written before.
module contiguous_list_engine_top #(
  parameter int DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  cle_in_if.sink    in_ch,
  cle_out_if.source out_ch
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int POSW   = cle_pkg::POS_W;
  localparam int VALW   = cle_pkg::VAL_W;
  localparam int CNTO_W = cle_pkg::CNT_OUT_W;
  localparam int CMPW   = (CW > POSW) ? CW : POSW;

  cle_pkg::state_t state_r, state_nxt;

  logic [cle_pkg::OP_W-1:0] op_r;
  logic [POSW-1:0]          pos_r;
  logic signed [VALW-1:0]   val_r;

  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            left_r, left_nxt;
  logic [AW-1:0]            src_r, src_nxt;
  logic [AW-1:0]            dst_r, dst_nxt;
  logic                     pend_r, pend_nxt;

  logic signed [VALW-1:0]   res_rd_r, res_rd_nxt;
  logic [POSW-1:0]          res_fpos_r, res_fpos_nxt;
  logic                     res_fnd_r, res_fnd_nxt;
  logic [cle_pkg::ST_W-1:0] res_st_r, res_st_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_load;
  logic signed [VALW-1:0]   out_rd_r;
  logic [POSW-1:0]          out_fpos_r;
  logic                     out_fnd_r;
  logic [CNTO_W-1:0]        out_cnt_r;
  logic [cle_pkg::ST_W-1:0] out_st_r;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [VALW-1:0]          mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [VALW-1:0]          mem_rdata;

  logic                     in_fire;
  logic [CMPW-1:0]          pos_x, cnt_x;
  logic                     pos_lt_cnt, pos_gt_cnt;
  logic                     hit;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign pos_x      = CMPW'(pos_r);
  assign cnt_x      = CMPW'(cnt_r);
  assign pos_lt_cnt = pos_x < cnt_x;
  assign pos_gt_cnt = pos_x > cnt_x;
  // search compare: stored word against the search key
  assign hit        = (op_r == cle_pkg::OP_SEARCH) && pend_r &&
                      (mem_rdata == val_r);

  cle_store #(
    .DEPTH (DEPTH),
    .WIDTH (VALW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    pend_nxt      = pend_r;
    res_rd_nxt    = res_rd_r;
    res_fpos_nxt  = res_fpos_r;
    res_fnd_nxt   = res_fnd_r;
    res_st_nxt    = res_st_r;
    mem_we        = 1'b0;
    mem_waddr     = dst_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = src_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      cle_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = cle_pkg::S_DECODE;
        end
      end

      cle_pkg::S_DECODE: begin
        res_rd_nxt   = '0;
        res_fpos_nxt = '0;
        res_fnd_nxt  = 1'b0;
        res_st_nxt   = cle_pkg::ST_OK;
        pend_nxt     = 1'b0;
        state_nxt    = cle_pkg::S_RESP;
        unique case (op_r)
          cle_pkg::OP_READ: begin
            if (pos_lt_cnt) begin
              mem_raddr = AW'(pos_r);
              state_nxt = cle_pkg::S_RDATA;
            end else begin
              res_st_nxt = cle_pkg::ST_POS;
            end
          end
          cle_pkg::OP_WRITE: begin
            if (pos_lt_cnt) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
              mem_wdata = val_r;
            end else begin
              res_st_nxt = cle_pkg::ST_POS;
            end
          end
          cle_pkg::OP_INSERT: begin
            if (pos_gt_cnt) begin
              res_st_nxt = cle_pkg::ST_POS;
            end else if (cnt_r == CW'(DEPTH)) begin
              res_st_nxt = cle_pkg::ST_FULL;
            end else begin
              // move words count-1 down to pos one place right
              left_nxt  = cnt_r - CW'(pos_r);
              src_nxt   = AW'(cnt_r - CW'(1));
              state_nxt = cle_pkg::S_WALK;
            end
          end
          cle_pkg::OP_REMOVE: begin
            if (pos_lt_cnt) begin
              // move words pos+1 up to count-1 one place left
              left_nxt  = cnt_r - CW'(pos_r) - CW'(1);
              src_nxt   = AW'(pos_r) + AW'(1);
              state_nxt = cle_pkg::S_WALK;
            end else begin
              res_st_nxt = cle_pkg::ST_POS;
            end
          end
          cle_pkg::OP_SEARCH: begin
            left_nxt  = cnt_r;
            src_nxt   = '0;
            state_nxt = cle_pkg::S_WALK;
          end
          default: begin
          end
        endcase
      end

      cle_pkg::S_WALK: begin
        // retire the word read last cycle
        if (pend_r && (op_r != cle_pkg::OP_SEARCH)) begin
          mem_we = 1'b1;
        end
        if (hit) begin
          res_fnd_nxt  = 1'b1;
          res_fpos_nxt = POSW'(dst_r);
          pend_nxt     = 1'b0;
          state_nxt    = cle_pkg::S_RESP;
        end else if (left_r != '0) begin
          pend_nxt = 1'b1;
          left_nxt = left_r - CW'(1);
          if (op_r == cle_pkg::OP_INSERT) begin
            dst_nxt = src_r + AW'(1);
            src_nxt = src_r - AW'(1);
          end else if (op_r == cle_pkg::OP_REMOVE) begin
            dst_nxt = src_r - AW'(1);
            src_nxt = src_r + AW'(1);
          end else begin
            dst_nxt = src_r;
            src_nxt = src_r + AW'(1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = cle_pkg::S_RESP;
          if (op_r == cle_pkg::OP_INSERT) begin
            state_nxt = cle_pkg::S_PUTV;
          end else if (op_r == cle_pkg::OP_REMOVE) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end

      cle_pkg::S_RDATA: begin
        res_rd_nxt = mem_rdata;
        state_nxt  = cle_pkg::S_RESP;
      end

      cle_pkg::S_PUTV: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = cle_pkg::S_RESP;
      end

      cle_pkg::S_RESP: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cle_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cle_pkg::S_IDLE;
      cnt_r       <= '0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.operation;
      pos_r <= in_ch.position;
      val_r <= in_ch.value;
    end
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    res_rd_r   <= res_rd_nxt;
    res_fpos_r <= res_fpos_nxt;
    res_fnd_r  <= res_fnd_nxt;
    res_st_r   <= res_st_nxt;
    if (out_load) begin
      out_rd_r   <= res_rd_r;
      out_fpos_r <= res_fpos_r;
      out_fnd_r  <= res_fnd_r;
      out_cnt_r  <= CNTO_W'(cnt_r);
      out_st_r   <= res_st_r;
    end
  end

  assign in_ch.ready           = (state_r == cle_pkg::S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_value     = out_rd_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.found          = out_fnd_r;
  assign out_ch.count          = out_cnt_r;
  assign out_ch.status         = out_st_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == cle_pkg::S_DECODE)
    else $error("accepted word not decoded next cycle");

  a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cle_pkg::S_WALK && pend_r && left_r != '0 &&
     op_r != cle_pkg::OP_SEARCH) |-> mem_waddr != mem_raddr)
    else $error("shift reads and writes the same entry");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cle_pkg::S_RESP && res_st_r == cle_pkg::ST_FULL) |->
    cnt_r == CW'(DEPTH))
    else $error("full status on a list that is not full");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fnd_r) |-> out_st_r == cle_pkg::ST_OK)
    else $error("found flag with error status");

endmodule

>>> design/cle_store.sv
module cle_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
